FILE: rtl/core/ptpc_pkg.sv
// package for the pitot tube pressure correction block
// constants, field widths and status codes; no dependencies
`default_nettype none

package ptpc_pkg;

  localparam int PRESSURE_WIDTH_DEF = 16;
  localparam int PRESSURE_FRAC_DEF  = 6;

  localparam int TEMP_W   = 15;
  localparam int ABS_W    = 17;
  localparam int TUBE_W   = 34;
  localparam int STATUS_W = 2;

  localparam logic [TUBE_W-1:0] TUBE_RESET = 34'd7499999832;

  // viscosity times 3.2e6 is VISC_BASE + VISC_SLOPE * t
  localparam int              VISC_W     = 27;
  localparam logic [26:0]     VISC_BASE  = 27'd12852928;
  localparam logic [26:0]     VISC_SLOPE = 27'd2420;
  // all constant factors as one integer in Q70
  localparam int              GAIN_W     = 20;
  localparam logic [19:0]     GAIN_Q70   = 20'd1033300;

  localparam int G_W         = VISC_W + TEMP_W;  // visc * t
  localparam int GG_W        = G_W + GAIN_W;     // visc * t * gain
  localparam int Q_NUM_W     = 52;               // numerator of the q32 divide
  localparam int Q_POS_SHIFT = 51;               // 8 * 2^48
  localparam int DEN_W       = 33;               // 2^32 - eps, Q32
  localparam int SQRT_OFFSET = 65536;            // 1.0 in Q16.16

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_UNDEF = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/ptpc_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
// standalone; used by pitot_tube_pressure_correction
`default_nettype none

module ptpc_div #(
  parameter int NUM_W  = 16,
  parameter int DIV_W  = 8,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DIV_W-1:0]  in_div,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  // numerator shifts out of the top while quotient bits shift in at the bottom
  logic [NUM_W-1:0]  nq   [1:NUM_W];
  logic [DIV_W-1:0]  rem  [1:NUM_W];
  logic [DIV_W-1:0]  dv   [1:NUM_W];
  logic [SIDE_W-1:0] side [1:NUM_W];
  logic              vld  [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0]  cur_nq;
    logic [DIV_W-1:0]  cur_rem;
    logic [DIV_W-1:0]  cur_dv;
    logic [SIDE_W-1:0] cur_side;
    logic              cur_vld;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign cur_nq   = in_num;
      assign cur_rem  = '0;
      assign cur_dv   = in_div;
      assign cur_side = in_side;
      assign cur_vld  = in_valid;
    end else begin : g_next
      assign cur_nq   = nq[k];
      assign cur_rem  = rem[k];
      assign cur_dv   = dv[k];
      assign cur_side = side[k];
      assign cur_vld  = vld[k];
    end

    assign shifted = {cur_rem, cur_nq[NUM_W-1]};
    assign take    = shifted >= {1'b0, cur_dv};
    assign diff    = shifted - {1'b0, cur_dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cur_vld;
      end
      if (en) begin
        rem[k+1]  <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        nq[k+1]   <= {cur_nq[NUM_W-2:0], take};
        dv[k+1]   <= cur_dv;
        side[k+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign out_quo   = nq[NUM_W];
  assign out_side  = side[NUM_W];

endmodule

`default_nettype wire

FILE: rtl/core/ptpc_sqrt.sv
// pipelined integer square root, one root bit per stage, with sideband
// standalone; used by pitot_tube_pressure_correction
`default_nettype none

module ptpc_sqrt #(
  parameter int ARG_W  = 16,
  parameter int SIDE_W = 1,
  parameter int ROOT_W = (ARG_W + 1) / 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ARG_W-1:0]  in_arg,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int VAL_W = 2 * ROOT_W;

  logic [VAL_W-1:0]  val  [1:ROOT_W];
  logic [ROOT_W:0]   rem  [1:ROOT_W];
  logic [ROOT_W-1:0] root [1:ROOT_W];
  logic [SIDE_W-1:0] side [1:ROOT_W];
  logic              vld  [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [VAL_W-1:0]  cur_val;
    logic [ROOT_W:0]   cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [SIDE_W-1:0] cur_side;
    logic              cur_vld;
    logic [ROOT_W+2:0] shifted;
    logic [ROOT_W+2:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign cur_val  = VAL_W'(in_arg);
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = in_side;
      assign cur_vld  = in_valid;
    end else begin : g_next
      assign cur_val  = val[k];
      assign cur_rem  = rem[k];
      assign cur_root = root[k];
      assign cur_side = side[k];
      assign cur_vld  = vld[k];
    end

    // bring down the next two bits and try root*4 + 1
    assign shifted = {cur_rem, cur_val[VAL_W-1 -: 2]};
    assign trial   = {1'b0, cur_root, 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cur_vld;
      end
      if (en) begin
        rem[k+1]  <= take ? (ROOT_W+1)'(shifted - trial) : (ROOT_W+1)'(shifted);
        root[k+1] <= {cur_root[ROOT_W-2:0], take};
        val[k+1]  <= {cur_val[VAL_W-3:0], 2'b00};
        side[k+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

`default_nettype wire

FILE: rtl/core/pitot_tube_pressure_correction.sv
// Hose-loss correction for a differential pressure sensor: each word in gives
// dp / (1 - eps) out, saturated, with the temperature passed through and a status.
// A new word is taken every cycle while the skid entry is empty. The dividers
// and square root work one bit per stage, and the divide by the constant
// 101 * 2^PRESSURE_FRAC_BITS takes three reciprocal stages. A two-entry output
// (register plus skid) decouples the sides; s_axis_tready only drops while the
// skid entry is full. Depends on ptpc_pkg, ptpc_div, ptpc_sqrt.
`default_nettype none

module pitot_tube_pressure_correction
  import ptpc_pkg::*;
#(
  parameter int PRESSURE_WIDTH     = PRESSURE_WIDTH_DEF,
  parameter int PRESSURE_FRAC_BITS = PRESSURE_FRAC_DEF,
  parameter int IN_DATA_W  = ((PRESSURE_WIDTH + TEMP_W + ABS_W + 7) / 8) * 8,
  parameter int OUT_DATA_W = ((PRESSURE_WIDTH + TEMP_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [TUBE_W-1:0]     cfg_wdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // diff_pressure, temperature, abs_pressure
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // corrected_pressure, temperature_out
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]        m_axis_tuser
);

  localparam int PW = PRESSURE_WIDTH;
  localparam int PF = PRESSURE_FRAC_BITS;
  localparam longint unsigned BASE8  = 64'd101 << PF;
  localparam longint unsigned UN_MAX = BASE8 + (64'd8 << (PW - 1));
  localparam int UN_W    = $clog2(UN_MAX + 64'd1);
  localparam int ARG_W   = UN_W + 32;
  localparam int ROOT_W  = (ARG_W + 1) / 2;
  localparam int QD_W    = (ROOT_W + 8 > PW) ? ROOT_W + 8 : PW;
  localparam int QV_W    = PF + 33;
  localparam int LH_W    = 64 + PF + 2;
  localparam int FULL_W  = LH_W + 33;
  localparam int RN_W    = PW + 32;
  localparam int SIDE_A_W = 3 + PW + UN_W + TEMP_W;
  localparam int SIDE_B_W = GG_W + 3 + PW + TEMP_W;
  localparam int SIDE_C_W = 2 + TEMP_W;
  localparam int OUT_W    = PW + TEMP_W;
  localparam logic [RN_W-1:0] SBIT = RN_W'(1) << (PW - 1);

  // reciprocals for un * 2^(32 - PF) / 101, exact over the whole un range
  localparam int DIV_K1 = UN_W + 7;
  localparam longint unsigned DIV_M1 = ((64'd1 << DIV_K1) + 64'd100) / 64'd101;
  localparam int M1_W    = $clog2(DIV_M1 + 64'd1);
  localparam int PR1_W   = UN_W + M1_W;
  localparam int FRAC_SH = 32 - PF;
  localparam int DIV_K2  = FRAC_SH + 14;
  localparam longint unsigned DIV_M2 = ((64'd1 << DIV_K2) + 64'd100) / 64'd101;
  localparam int M2_W    = $clog2(DIV_M2 + 64'd1);
  localparam int PR2_W   = 7 + M2_W;

  // configuration
  logic [TUBE_W-1:0] tube;

  always_ff @(posedge clk) begin
    if (rst) begin
      tube <= TUBE_RESET;
    end else if (cfg_we) begin
      tube <= cfg_wdata;
    end
  end

  logic en;
  logic skid_valid;
  logic out_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // front: decode the word, sign and magnitude, sqrt argument numerator
  logic signed [PW-1:0] raw;
  logic [TEMP_W-1:0]    t_in;
  logic [ABS_W-1:0]     p_in;
  logic                 neg_in;
  logic [PW-1:0]        mag_in;
  logic signed [UN_W:0] num_in;

  assign raw    = s_axis_tdata[PW-1:0];
  assign t_in   = s_axis_tdata[PW+TEMP_W-1:PW];
  assign p_in   = s_axis_tdata[PW+TEMP_W+ABS_W-1:PW+TEMP_W];
  assign neg_in = raw[PW-1];
  assign mag_in = neg_in ? PW'(-raw) : PW'(raw);
  assign num_in = signed'((UN_W+1)'(BASE8)) + ((UN_W+1)'(raw) <<< 3);

  logic               s1_valid, s1_ok, s1_neg, s1_numneg;
  logic [PW-1:0]      s1_mag;
  logic [UN_W-1:0]    s1_un;
  logic [TEMP_W-1:0]  s1_t;
  logic [ABS_W-1:0]   s1_p;
  logic [VISC_W-1:0]  s1_visc;

  logic               s2_valid, s2_ok, s2_neg, s2_numneg;
  logic [PW-1:0]      s2_mag;
  logic [UN_W-1:0]    s2_un;
  logic [TEMP_W-1:0]  s2_t;
  logic [ABS_W-1:0]   s2_p;
  logic [G_W-1:0]     s2_g;

  logic               s3_valid, s3_ok, s3_neg, s3_numneg;
  logic [PW-1:0]      s3_mag;
  logic [UN_W-1:0]    s3_un;
  logic [TEMP_W-1:0]  s3_t;
  logic [ABS_W-1:0]   s3_p;
  logic [GG_W-1:0]    s3_gg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    if (en) begin
      s1_ok     <= (raw != '0) && (p_in != '0);
      s1_neg    <= neg_in;
      s1_numneg <= num_in[UN_W];
      s1_mag    <= mag_in;
      s1_un     <= num_in[UN_W] ? '0 : num_in[UN_W-1:0];
      s1_t      <= t_in;
      s1_p      <= p_in;
      s1_visc   <= VISC_BASE + VISC_SLOPE * VISC_W'(t_in);

      s2_ok     <= s1_ok;
      s2_neg    <= s1_neg;
      s2_numneg <= s1_numneg;
      s2_mag    <= s1_mag;
      s2_un     <= s1_un;
      s2_t      <= s1_t;
      s2_p      <= s1_p;
      s2_g      <= G_W'(s1_visc) * G_W'(s1_t);

      s3_ok     <= s2_ok;
      s3_neg    <= s2_neg;
      s3_numneg <= s2_numneg;
      s3_mag    <= s2_mag;
      s3_un     <= s2_un;
      s3_t      <= s2_t;
      s3_p      <= s2_p;
      s3_gg     <= GG_W'(s2_g) * GG_W'(GAIN_Q70);
    end
  end

  // r = visc * t * gain / p
  logic                rd_valid;
  logic [GG_W-1:0]     rd_r;
  logic [SIDE_A_W-1:0] rd_side;
  logic                a_ok, a_neg, a_numneg;
  logic [PW-1:0]       a_mag;
  logic [UN_W-1:0]     a_un;
  logic [TEMP_W-1:0]   a_t;

  ptpc_div #(.NUM_W(GG_W), .DIV_W(ABS_W), .SIDE_W(SIDE_A_W)) u_rdiv (
    .clk, .rst, .en,
    .in_valid (s3_valid),
    .in_num   (s3_gg),
    .in_div   (s3_p),
    .in_side  ({s3_ok, s3_neg, s3_numneg, s3_mag, s3_un, s3_t}),
    .out_valid(rd_valid),
    .out_quo  (rd_r),
    .out_side (rd_side)
  );

  assign {a_ok, a_neg, a_numneg, a_mag, a_un, a_t} = rd_side;

  // arg = 1 + 8 dp / 101 in Q32: un / 101 by reciprocal, then the
  // remainder scaled by 2^(32 - PF) / 101 by a second reciprocal
  logic                c1_valid;
  logic [UN_W-1:0]     c1_un;
  logic [PR1_W-1:0]    c1_prod;
  logic [SIDE_B_W-1:0] c1_side;
  logic [UN_W-1:0]     c1_q, c1_qm;

  logic                c2_valid;
  logic [UN_W-1:0]     c2_q;
  logic [6:0]          c2_rem;
  logic [SIDE_B_W-1:0] c2_side;
  logic [PR2_W-1:0]    c2_frac_pr;

  logic                ad_valid;
  logic [ARG_W-1:0]    ad_arg;
  logic [SIDE_B_W-1:0] ad_side;

  assign c1_q       = UN_W'(c1_prod >> DIV_K1);
  assign c1_qm      = c1_q * UN_W'(101);
  assign c2_frac_pr = PR2_W'(c2_rem) * PR2_W'(DIV_M2);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      ad_valid <= 1'b0;
    end else if (en) begin
      c1_valid <= rd_valid;
      c2_valid <= c1_valid;
      ad_valid <= c2_valid;
    end
    if (en) begin
      c1_un   <= a_un;
      c1_prod <= PR1_W'(a_un) * PR1_W'(DIV_M1);
      c1_side <= {rd_r, a_ok, a_neg, a_numneg, a_mag, a_t};

      c2_q    <= c1_q;
      c2_rem  <= 7'(c1_un - c1_qm);
      c2_side <= c1_side;

      ad_arg  <= (ARG_W'(c2_q) << FRAC_SH) + ARG_W'(c2_frac_pr >> 14);
      ad_side <= c2_side;
    end
  end

  logic                sq_valid;
  logic [ROOT_W-1:0]   sq_root;
  logic [SIDE_B_W-1:0] sq_side;
  logic [GG_W-1:0]     b_r;
  logic                b_ok, b_neg, b_numneg;
  logic [PW-1:0]       b_mag;
  logic [TEMP_W-1:0]   b_t;

  ptpc_sqrt #(.ARG_W(ARG_W), .SIDE_W(SIDE_B_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (ad_valid),
    .in_arg   (ad_arg),
    .in_side  (ad_side),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign {b_r, b_ok, b_neg, b_numneg, b_mag, b_t} = sq_side;

  // q32 = 8 / (101 (s + 1)), or 1 / |dp| when the root argument is negative
  logic [Q_NUM_W-1:0] qn_in;
  logic [QD_W-1:0]    qd_in;

  assign qn_in = b_numneg ? (Q_NUM_W'(1) << (PF + 32)) : (Q_NUM_W'(1) << Q_POS_SHIFT);
  assign qd_in = b_numneg ? QD_W'(b_mag)
                          : (QD_W'(sq_root) + QD_W'(SQRT_OFFSET)) * QD_W'(101);

  logic                qd_valid;
  logic [Q_NUM_W-1:0]  qd_q;
  logic [SIDE_B_W-1:0] qd_side;
  logic [GG_W-1:0]     c_r;
  logic                c_ok, c_neg, c_numneg;
  logic [PW-1:0]       c_mag;
  logic [TEMP_W-1:0]   c_t;

  ptpc_div #(.NUM_W(Q_NUM_W), .DIV_W(QD_W), .SIDE_W(SIDE_B_W)) u_qdiv (
    .clk, .rst, .en,
    .in_valid (sq_valid),
    .in_num   (qn_in),
    .in_div   (qd_in),
    .in_side  (sq_side),
    .out_valid(qd_valid),
    .out_quo  (qd_q),
    .out_side (qd_side)
  );

  assign {c_r, c_ok, c_neg, c_numneg, c_mag, c_t} = qd_side;

  // eps = r * tube / 2^32 * q32 / 2^44, in partial products
  logic              m1_valid, m1_ok, m1_neg;
  logic [PW-1:0]     m1_mag;
  logic [TEMP_W-1:0] m1_t;
  logic [QV_W-1:0]   m1_q;
  logic [65:0]       m1_pr0;
  logic [63:0]       m1_pr1;

  logic              m2_valid, m2_ok, m2_neg;
  logic [PW-1:0]     m2_mag;
  logic [TEMP_W-1:0] m2_t;
  logic [QV_W-1:0]   m2_q;
  logic [63:0]       m2_m;

  logic              m3_valid, m3_ok, m3_neg;
  logic [PW-1:0]     m3_mag;
  logic [TEMP_W-1:0] m3_t;
  logic [63:0]       m3_p00, m3_p10;
  logic [PF+32:0]    m3_p01, m3_p11;

  logic              m4_valid, m4_ok, m4_neg;
  logic [PW-1:0]     m4_mag;
  logic [TEMP_W-1:0] m4_t;
  logic [LH_W-1:0]   m4_lo, m4_hi;

  logic              m5_valid, m5_def, m5_neg;
  logic [PW-1:0]     m5_mag;
  logic [TEMP_W-1:0] m5_t;
  logic [DEN_W-1:0]  m5_den;

  logic [FULL_W-1:0] full;

  assign full = FULL_W'(m4_lo) + (FULL_W'(m4_hi) << 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      m5_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= qd_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      m5_valid <= m4_valid;
    end
    if (en) begin
      m1_ok  <= c_ok;
      m1_neg <= c_neg;
      m1_mag <= c_mag;
      m1_t   <= c_t;
      m1_q   <= qd_q[QV_W-1:0];
      m1_pr0 <= 66'(c_r[31:0]) * 66'(tube);
      m1_pr1 <= 64'(c_r[GG_W-1:32]) * 64'(tube);

      m2_ok  <= m1_ok;
      m2_neg <= m1_neg;
      m2_mag <= m1_mag;
      m2_t   <= m1_t;
      m2_q   <= m1_q;
      m2_m   <= m1_pr1 + 64'(m1_pr0[65:32]);

      m3_ok  <= m2_ok;
      m3_neg <= m2_neg;
      m3_mag <= m2_mag;
      m3_t   <= m2_t;
      m3_p00 <= 64'(m2_m[31:0]) * 64'(m2_q[31:0]);
      m3_p10 <= 64'(m2_m[63:32]) * 64'(m2_q[31:0]);
      m3_p01 <= (PF+33)'(m2_m[31:0]) * (PF+33)'(m2_q[QV_W-1:32]);
      m3_p11 <= (PF+33)'(m2_m[63:32]) * (PF+33)'(m2_q[QV_W-1:32]);

      m4_ok  <= m3_ok;
      m4_neg <= m3_neg;
      m4_mag <= m3_mag;
      m4_t   <= m3_t;
      m4_lo  <= LH_W'(m3_p00) + (LH_W'(m3_p01) << 32);
      m4_hi  <= LH_W'(m3_p10) + (LH_W'(m3_p11) << 32);

      // eps must stay below one for a positive denominator
      m5_def <= !m4_ok || (full[FULL_W-1:76] != '0);
      m5_neg <= m4_neg;
      m5_mag <= m4_mag;
      m5_t   <= m4_t;
      m5_den <= (DEN_W'(1) << 32) - DEN_W'(full[75:44]);
    end
  end

  // |dp| / (1 - eps), rounded half away from zero
  logic                fd_valid;
  logic [RN_W-1:0]     fd_res;
  logic [SIDE_C_W-1:0] fd_side;
  logic                f_def, f_neg;
  logic [TEMP_W-1:0]   f_t;

  ptpc_div #(.NUM_W(RN_W), .DIV_W(DEN_W), .SIDE_W(SIDE_C_W)) u_fdiv (
    .clk, .rst, .en,
    .in_valid (m5_valid),
    .in_num   ({m5_mag, m5_den[32:1]}),
    .in_div   (m5_den),
    .in_side  ({m5_def, m5_neg, m5_t}),
    .out_valid(fd_valid),
    .out_quo  (fd_res),
    .out_side (fd_side)
  );

  assign {f_def, f_neg, f_t} = fd_side;

  logic [RN_W-1:0] lim;
  logic [RN_W-1:0] res_sat;
  logic [PW-1:0]   corr;
  status_t         fin_status;
  logic [OUT_W-1:0] fin_data;
  logic            push;

  assign lim = f_neg ? SBIT : SBIT - RN_W'(1);

  always_comb begin
    res_sat    = fd_res;
    fin_status = STATUS_OK;
    if (f_def) begin
      res_sat    = '0;
      fin_status = STATUS_UNDEF;
    end else if (fd_res > lim) begin
      res_sat    = lim;
      fin_status = STATUS_SAT;
    end
  end

  assign corr     = f_neg ? PW'(-res_sat[PW-1:0]) : res_sat[PW-1:0];
  assign fin_data = {f_t, corr};
  assign push     = en && fd_valid;

  // output register with one skid entry
  logic [OUT_W-1:0]    out_data, skid_data;
  logic [STATUS_W-1:0] out_user, skid_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        out_user   <= skid_user;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_data <= fin_data;
          out_user <= fin_status;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= fin_data;
      skid_user  <= fin_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_data);
  assign m_axis_tuser  = out_user;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
    else $error("skid filled while the output was free");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_user == STATUS_UNDEF) |-> (out_data[PW-1:0] == '0))
    else $error("undefined result with nonzero pressure");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_user == STATUS_SAT) |->
      (out_data[PW-1:0] == SBIT[PW-1:0] || out_data[PW-1:0] == PW'(SBIT - RN_W'(1))))
    else $error("saturated result not at a range limit");
`endif

endmodule

`default_nettype wire
